>>> design/point_covariance_3x3_macros.svh
// Assertion macros shared by the covariance block.
`ifndef POINT_COVARIANCE_3X3_MACROS_SVH
`define POINT_COVARIANCE_3X3_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCOV_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCOV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/pcov_pkg.sv
// Types and constants shared by the covariance controller, datapath and top level.
`timescale 1ns / 1ps
package pcov_pkg;
	localparam int FIELD_W   = 24;
	localparam int COV_W     = 50;
	localparam int SUM_W     = 64;
	localparam int NUM_ENT   = 6;
	localparam int BIT_CNT_W = $clog2(SUM_W);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;

	typedef enum logic [2:0] {
		ENT_XX,
		ENT_YY,
		ENT_ZZ,
		ENT_XY,
		ENT_XZ,
		ENT_YZ
	} ent_t;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_DRAIN,
		ST_LOAD,
		ST_STEP,
		ST_STORE
	} pcov_state_t;

	typedef struct packed {
		logic pt_load;
		logic div_load;
		logic div_step;
		logic div_store;
		logic publish;
		logic zero_out;
		logic too_few;
		logic cap_hit;
		ent_t entry;
	} pcov_cmd_t;
endpackage

>>> design/pcov_dpath.sv
// Covariance datapath: centering, product pipeline, sums, shared divider, result registers.
`timescale 1ns / 1ps
module pcov_dpath
	import pcov_pkg::*;
#(
	parameter int COORD_WIDTH = 24,
	parameter int MAX_POINTS  = 16384
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcov_cmd_t                     cmd,
	input  logic [$clog2(MAX_POINTS+1)-1:0] divisor,
	input  logic                          cfg_valid,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [FIELD_W-1:0]            cfg_data,
	input  logic signed [FIELD_W-1:0]     point_x,
	input  logic signed [FIELD_W-1:0]     point_y,
	input  logic signed [FIELD_W-1:0]     point_z,
	output logic                          pipe_busy,
	output logic signed [COV_W-1:0]       cov_xx,
	output logic signed [COV_W-1:0]       cov_yy,
	output logic signed [COV_W-1:0]       cov_zz,
	output logic signed [COV_W-1:0]       cov_xy,
	output logic signed [COV_W-1:0]       cov_xz,
	output logic signed [COV_W-1:0]       cov_yz,
	output logic                          too_few_points,
	output logic                          capacity_exceeded
);
	localparam int DW    = COORD_WIDTH + 1;
	localparam int PW    = 2 * DW;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic signed [COORD_WIDTH-1:0] ctr_x_q, ctr_y_q, ctr_z_q;
	logic signed [DW-1:0]          px, py, pz, cx, cy, cz;
	logic signed [DW-1:0]          dx_s1, dy_s1, dz_s1;
	logic                          v_s1, v_s2;
	logic signed [PW-1:0]          prod_s2 [NUM_ENT];
	logic signed [SUM_W-1:0]       sum_q [NUM_ENT];
	logic signed [SUM_W-1:0]       sum_sel;
	logic                          neg_q;
	logic [SUM_W-1:0]              dq_q;
	logic [SUM_W-1:0]              quot;
	logic [CNT_W-1:0]              rem_q;
	logic [CNT_W:0]                trial, diff;
	logic                          ge;
	logic signed [COV_W-1:0]       cov_q [NUM_ENT];
	logic                          too_few_q, cap_q;

	assign px = {point_x[COORD_WIDTH-1], point_x[COORD_WIDTH-1:0]};
	assign py = {point_y[COORD_WIDTH-1], point_y[COORD_WIDTH-1:0]};
	assign pz = {point_z[COORD_WIDTH-1], point_z[COORD_WIDTH-1:0]};
	assign cx = {ctr_x_q[COORD_WIDTH-1], ctr_x_q};
	assign cy = {ctr_y_q[COORD_WIDTH-1], ctr_y_q};
	assign cz = {ctr_z_q[COORD_WIDTH-1], ctr_z_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_x_q <= '0;
			ctr_y_q <= '0;
			ctr_z_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CENTER_X: ctr_x_q <= cfg_data[COORD_WIDTH-1:0];
				CFG_CENTER_Y: ctr_y_q <= cfg_data[COORD_WIDTH-1:0];
				CFG_CENTER_Z: ctr_z_q <= cfg_data[COORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.pt_load;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pt_load) begin
			dx_s1 <= px - cx;
			dy_s1 <= py - cy;
			dz_s1 <= pz - cz;
		end
		if (v_s1) begin
			prod_s2[ENT_XX] <= dx_s1 * dx_s1;
			prod_s2[ENT_YY] <= dy_s1 * dy_s1;
			prod_s2[ENT_ZZ] <= dz_s1 * dz_s1;
			prod_s2[ENT_XY] <= dx_s1 * dy_s1;
			prod_s2[ENT_XZ] <= dx_s1 * dz_s1;
			prod_s2[ENT_YZ] <= dy_s1 * dz_s1;
		end
	end

	assign pipe_busy = v_s1 | v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENT; i++) sum_q[i] <= '0;
		end else if (cmd.publish) begin
			for (int i = 0; i < NUM_ENT; i++) sum_q[i] <= '0;
		end else if (v_s2) begin
			for (int i = 0; i < NUM_ENT; i++) sum_q[i] <= sum_q[i] + SUM_W'(prod_s2[i]);
		end
	end

	assign sum_sel = sum_q[cmd.entry];
	assign trial   = {rem_q, dq_q[SUM_W-1]};
	assign ge      = trial >= {1'b0, divisor};
	assign diff    = trial - {1'b0, divisor};
	assign quot    = neg_q ? -dq_q : dq_q;

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			neg_q <= sum_sel[SUM_W-1];
			dq_q  <= sum_sel[SUM_W-1] ? -sum_sel : sum_sel;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			dq_q  <= {dq_q[SUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.zero_out) begin
			for (int i = 0; i < NUM_ENT; i++) cov_q[i] <= '0;
		end else if (cmd.div_store) begin
			cov_q[cmd.entry] <= quot[COV_W-1:0];
		end
		if (cmd.publish) begin
			too_few_q <= cmd.too_few;
			cap_q     <= cmd.cap_hit;
		end
	end

	assign cov_xx            = cov_q[ENT_XX];
	assign cov_yy            = cov_q[ENT_YY];
	assign cov_zz            = cov_q[ENT_ZZ];
	assign cov_xy            = cov_q[ENT_XY];
	assign cov_xz            = cov_q[ENT_XZ];
	assign cov_yz            = cov_q[ENT_YZ];
	assign too_few_points    = too_few_q;
	assign capacity_exceeded = cap_q;
endmodule

>>> design/pcov_ctrl.sv
// Covariance controller: point counting, drain, divider sequencing and result handshake.
`timescale 1ns / 1ps
`include "point_covariance_3x3_macros.svh"
module pcov_ctrl
	import pcov_pkg::*;
#(
	parameter int MAX_POINTS = 16384
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            final_point,
	output logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            pipe_busy,
	output pcov_cmd_t                       cmd,
	output logic [$clog2(MAX_POINTS+1)-1:0] divisor
);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	pcov_state_t          state_q, state_d;
	logic [CNT_W-1:0]     count_q, cnt_after, divisor_q;
	logic                 ovf_q, too_few_q, cap_q, out_valid_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	ent_t                 entry_q;
	logic                 keep, in_rdy, in_fire, bit_last;

	assign keep      = count_q < CNT_W'(MAX_POINTS);
	assign cnt_after = keep ? count_q + CNT_W'(1) : count_q;
	assign bit_last  = bit_cnt_q == BIT_CNT_W'(SUM_W - 1);
	assign in_fire   = in_valid & in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_RUN;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.entry   = entry_q;
		cmd.too_few = too_few_q;
		cmd.cap_hit = cap_q;
		in_rdy      = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				in_rdy = 1'b1;
				if (in_valid) begin
					cmd.pt_load = keep;
					if (final_point) state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy && !out_valid_q) begin
					if (too_few_q) begin
						cmd.zero_out = 1'b1;
						cmd.publish  = 1'b1;
						state_d      = ST_RUN;
					end else begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_STEP;
			end
			ST_STEP: begin
				cmd.div_step = 1'b1;
				if (bit_last) state_d = ST_STORE;
			end
			ST_STORE: begin
				cmd.div_store = 1'b1;
				if (entry_q == ENT_YZ) begin
					cmd.publish = 1'b1;
					state_d     = ST_RUN;
				end else begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			too_few_q   <= 1'b0;
			cap_q       <= 1'b0;
			divisor_q   <= '0;
			bit_cnt_q   <= '0;
			entry_q     <= ENT_XX;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (final_point) begin
					count_q   <= '0;
					ovf_q     <= 1'b0;
					too_few_q <= cnt_after < CNT_W'(2);
					cap_q     <= ovf_q | ~keep;
					divisor_q <= cnt_after - CNT_W'(1);
					entry_q   <= ENT_XX;
				end else begin
					count_q <= cnt_after;
					ovf_q   <= ovf_q | ~keep;
				end
			end
			if (cmd.div_load) bit_cnt_q <= '0;
			else if (cmd.div_step) bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
			if (cmd.div_store && entry_q != ENT_YZ) entry_q <= ent_t'(entry_q + 3'd1);
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = in_rdy;
	assign out_valid = out_valid_q;
	assign divisor   = divisor_q;

	`PCOV_ASSERT_HOLDS(a_pub_free, clk, arst_n, cmd.publish, !out_valid_q, "result overwrites a pending beat")
	`PCOV_ASSERT_HOLDS(a_div_quiet, clk, arst_n, state_q == ST_LOAD, !pipe_busy, "divider loads while sums still move")
	`PCOV_ASSERT_HOLDS(a_cnt_cap, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_POINTS), "point count above capacity")
	`PCOV_ASSERT_NEXT(a_step_end, clk, arst_n, state_q == ST_STEP && bit_last, state_q == ST_STORE, "divider ran past its last bit")
endmodule

>>> design/point_covariance_3x3.sv
// Top level of the 3x3 point covariance block. Points are taken one per clock while a cloud
// streams in; each is centered, multiplied out in a two-stage product pipeline and added to
// six 64-bit sums. A point marked final holds the input through a drain that lasts while the
// product pipeline still holds points or an earlier result still waits to be taken.
// Then one shared bit-serial divider, with the input still held, works through the six sums
// in turn (load, one step for each of the 64 quotient bits, store); with fewer than two
// points the zero result is published in the last drain cycle. A finished result sits
// in the output registers while the next cloud streams in; a second final point waits for
// it to be taken. Configuration is always ready and takes effect at once.
`timescale 1ns / 1ps
module point_covariance_3x3
	import pcov_pkg::*;
#(
	parameter int COORD_WIDTH = 24,
	parameter int MAX_POINTS  = 16384
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [FIELD_W-1:0]        cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [FIELD_W-1:0] point_x,
	input  logic signed [FIELD_W-1:0] point_y,
	input  logic signed [FIELD_W-1:0] point_z,
	input  logic                      final_point,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COV_W-1:0]   cov_xx,
	output logic signed [COV_W-1:0]   cov_yy,
	output logic signed [COV_W-1:0]   cov_zz,
	output logic signed [COV_W-1:0]   cov_xy,
	output logic signed [COV_W-1:0]   cov_xz,
	output logic signed [COV_W-1:0]   cov_yz,
	output logic                      too_few_points,
	output logic                      capacity_exceeded
);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	pcov_cmd_t        cmd;
	logic [CNT_W-1:0] divisor;
	logic             pipe_busy;

	assign cfg_ready = 1'b1;

	pcov_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.final_point(final_point),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pipe_busy  (pipe_busy),
		.cmd        (cmd),
		.divisor    (divisor)
	);

	pcov_dpath #(
		.COORD_WIDTH(COORD_WIDTH),
		.MAX_POINTS (MAX_POINTS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.divisor          (divisor),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.point_x          (point_x),
		.point_y          (point_y),
		.point_z          (point_z),
		.pipe_busy        (pipe_busy),
		.cov_xx           (cov_xx),
		.cov_yy           (cov_yy),
		.cov_zz           (cov_zz),
		.cov_xy           (cov_xy),
		.cov_xz           (cov_xz),
		.cov_yz           (cov_yz),
		.too_few_points   (too_few_points),
		.capacity_exceeded(capacity_exceeded)
	);
endmodule

>>> verif/tb_point_covariance_3x3.sv
// Self-checking testbench for point_covariance_3x3: clouds of points against a built-in covariance predictor.
`timescale 1ns / 1ps
module tb_point_covariance_3x3;
	import pcov_pkg::*;

	typedef logic signed [FIELD_W-1:0] coord_t;

	typedef struct packed {
		logic [NUM_ENT-1:0][COV_W-1:0] ent;
		logic                          too_few;
		logic                          cap_hit;
	} cov_result_t;

	localparam int                   MAX_PTS     = 16384;
	localparam int                   SETTLE_CYC  = 16;
	localparam int                   DRAIN_LIMIT = 20000;
	localparam int                   TIMEOUT_NS  = 20000000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
	localparam coord_t               COORD_MAX   = 24'sh7fffff;
	localparam coord_t               COORD_MIN   = 24'sh800000;
	localparam coord_t               COORD_ZERO  = 24'sh000000;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [FIELD_W-1:0]        cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [FIELD_W-1:0] point_x = '0;
	logic signed [FIELD_W-1:0] point_y = '0;
	logic signed [FIELD_W-1:0] point_z = '0;
	logic                      final_point = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [COV_W-1:0]   cov_xx;
	logic signed [COV_W-1:0]   cov_yy;
	logic signed [COV_W-1:0]   cov_zz;
	logic signed [COV_W-1:0]   cov_xy;
	logic signed [COV_W-1:0]   cov_xz;
	logic signed [COV_W-1:0]   cov_yz;
	logic                      too_few_points;
	logic                      capacity_exceeded;

	int   idle_pct = 10;
	logic out_hold = 1'b0;
	int   hold_len = 0;
	event hold_start;

	coord_t      ctr_x, ctr_y, ctr_z;
	longint      prod_sum [NUM_ENT];
	int unsigned kept_pts;
	bit          pts_dropped;
	cov_result_t cov_expected [$];

	int n_points  = 0;
	int n_clouds  = 0;
	int n_cfg     = 0;
	int n_results = 0;
	int n_errors  = 0;

	point_covariance_3x3 #(
		.COORD_WIDTH(FIELD_W),
		.MAX_POINTS (MAX_PTS)
	) uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.point_x          (point_x),
		.point_y          (point_y),
		.point_z          (point_z),
		.final_point      (final_point),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.cov_xx           (cov_xx),
		.cov_yy           (cov_yy),
		.cov_zz           (cov_zz),
		.cov_xy           (cov_xy),
		.cov_xz           (cov_xz),
		.cov_yz           (cov_yz),
		.too_few_points   (too_few_points),
		.capacity_exceeded(capacity_exceeded)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		out_ready <= !out_hold && ($urandom_range(0, 99) >= idle_pct);
	end

	initial begin
		forever begin
			@(hold_start);
			out_hold <= 1'b1;
			repeat (hold_len) @(posedge clk);
			out_hold <= 1'b0;
		end
	end

	function automatic void clear_cloud();
		foreach (prod_sum[i]) prod_sum[i] = 0;
		kept_pts = 0;
		pts_dropped = 1'b0;
	endfunction

	initial begin
		ctr_x = COORD_ZERO;
		ctr_y = COORD_ZERO;
		ctr_z = COORD_ZERO;
		clear_cloud();
	end

	function automatic void accumulate_point(coord_t px, coord_t py, coord_t pz, logic fin);
		longint      dx, dy, dz, q;
		cov_result_t r;
		if (kept_pts < MAX_PTS) begin
			dx = longint'(px) - longint'(ctr_x);
			dy = longint'(py) - longint'(ctr_y);
			dz = longint'(pz) - longint'(ctr_z);
			prod_sum[ENT_XX] += dx * dx;
			prod_sum[ENT_YY] += dy * dy;
			prod_sum[ENT_ZZ] += dz * dz;
			prod_sum[ENT_XY] += dx * dy;
			prod_sum[ENT_XZ] += dx * dz;
			prod_sum[ENT_YZ] += dy * dz;
			kept_pts++;
		end else begin
			pts_dropped = 1'b1;
		end
		if (!fin)
			return;
		r = '0;
		if (kept_pts < 2) begin
			r.too_few = 1'b1;
		end else begin
			for (int i = 0; i < NUM_ENT; i++) begin
				q = prod_sum[i] / longint'(kept_pts - 1);
				r.ent[i] = q[COV_W-1:0];
			end
		end
		r.cap_hit = pts_dropped;
		cov_expected = {cov_expected, r};
		n_clouds++;
		clear_cloud();
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got_val, logic [63:0] want_val);
		n_errors++;
		if (n_errors <= 40)
			$display("mismatch at result %0d, %s: got %h, expected %h",
				n_results, what, got_val, want_val);
	endtask

	always @(posedge clk) begin : check_results
		cov_result_t                   want;
		logic [NUM_ENT-1:0][COV_W-1:0] got;
		ent_t                          which;
		if (arst_n && out_valid && out_ready) begin
			got[ENT_XX] = cov_xx;
			got[ENT_YY] = cov_yy;
			got[ENT_ZZ] = cov_zz;
			got[ENT_XY] = cov_xy;
			got[ENT_XZ] = cov_xz;
			got[ENT_YZ] = cov_yz;
			if (cov_expected.size() == 0) begin
				report_mismatch("result with none pending", '0, '0);
			end else begin
				want = cov_expected.pop_front();
				for (int i = 0; i < NUM_ENT; i++) begin
					which = ent_t'(i);
					if (got[i] !== want.ent[i])
						report_mismatch(which.name(), got[i], want.ent[i]);
				end
				if (too_few_points !== want.too_few)
					report_mismatch("too_few_points", too_few_points, want.too_few);
				if (capacity_exceeded !== want.cap_hit)
					report_mismatch("capacity_exceeded", capacity_exceeded, want.cap_hit);
				n_results++;
			end
		end
	end

	function automatic coord_t pick_coord(coord_t around);
		logic [31:0] raw;
		raw = $urandom();
		case ($urandom_range(0, 9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2, 3, 4: return around + {11'd0, raw[12:0]} - 24'd4096;
			default: return raw[FIELD_W-1:0];
		endcase
	endfunction

	task automatic send_point(coord_t px, coord_t py, coord_t pz, logic fin);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		point_x     <= px;
		point_y     <= py;
		point_z     <= pz;
		final_point <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		accumulate_point(px, py, pz, fin);
		n_points++;
	endtask

	task automatic send_cloud(int size);
		coord_t ax, ay, az;
		ax = pick_coord(ctr_x);
		ay = pick_coord(ctr_y);
		az = pick_coord(ctr_z);
		for (int i = 0; i < size; i++)
			send_point(pick_coord(ax), pick_coord(ay), pick_coord(az), i == size - 1);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coord_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_CENTER_X: ctr_x = val;
			CFG_CENTER_Y: ctr_y = val;
			CFG_CENTER_Z: ctr_z = val;
			default: ;
		endcase
		n_cfg++;
	endtask

	task automatic set_centers(coord_t vx, coord_t vy, coord_t vz);
		write_reg(CFG_CENTER_X, vx);
		write_reg(CFG_CENTER_Y, vy);
		write_reg(CFG_CENTER_Z, vz);
		cfg_valid <= 1'b0;
	endtask

	// hold input low and wait for every pending result, then let the pipeline settle
	task automatic quiesce();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (cov_expected.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic test_reset_state();
		send_point(COORD_MAX, COORD_MIN, COORD_ZERO, 1'b1);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
	endtask

	task automatic test_center_registers();
		quiesce();
		write_reg(CFG_UNUSED, COORD_MAX);
		set_centers(COORD_MAX, COORD_MIN, 24'sh123456);
		send_point(COORD_MIN, COORD_MAX, COORD_ZERO, 1'b0);
		send_point(COORD_MAX, COORD_MIN, -24'sd1, 1'b0);
		send_point(COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b1);
		quiesce();
		set_centers(COORD_MIN, COORD_MAX, COORD_MIN);
		send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
		send_point(COORD_MIN, COORD_MAX, 24'sh5a5a5a, 1'b1);
	endtask

	// negative sums that do not divide evenly
	task automatic test_rounding();
		quiesce();
		set_centers(COORD_ZERO, COORD_ZERO, COORD_ZERO);
		send_point(24'sd1, -24'sd1, 24'sd2, 1'b0);
		send_point(24'sd2, -24'sd2, -24'sd1, 1'b0);
		send_point(COORD_ZERO, COORD_ZERO, 24'sd1, 1'b0);
		send_point(COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b1);
	endtask

	task automatic test_output_backpressure();
		quiesce();
		idle_pct <= 0;
		hold_len = 1500;
		-> hold_start;
		repeat (8) send_cloud($urandom_range(3, 6));
		idle_pct <= 10;
		quiesce();
	endtask

	// run one cloud past capacity with the final beat dropped, then confirm the flag clears
	task automatic test_capacity_limit();
		quiesce();
		idle_pct <= 0;
		set_centers(pick_coord(COORD_ZERO), pick_coord(COORD_ZERO), pick_coord(COORD_ZERO));
		send_cloud(MAX_PTS + 3);
		send_cloud(2);
		idle_pct <= 10;
	endtask

	task automatic test_random_clouds();
		int sent;
		int size;
		for (int ph = 0; ph < 4; ph++) begin
			quiesce();
			case (ph)
				1: set_centers(COORD_MAX, COORD_MAX, COORD_MAX);
				2: set_centers(COORD_MIN, COORD_MIN, COORD_MIN);
				default: set_centers(pick_coord(COORD_ZERO), pick_coord(COORD_ZERO),
					pick_coord(COORD_ZERO));
			endcase
			sent = 0;
			while (sent < 200) begin
				case ($urandom_range(0, 9))
					0: size = 1;
					1: size = 2;
					default: size = $urandom_range(3, 24);
				endcase
				send_cloud(size);
				sent += size;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_center_registers();
		test_rounding();
		test_output_backpressure();
		test_capacity_limit();
		test_random_clouds();
		quiesce();
		if (cov_expected.size() != 0)
			report_mismatch("results never delivered", cov_expected.size(), 0);
		$display("sent %0d points in %0d clouds, checked %0d covariance results, %0d register writes",
			n_points, n_clouds, n_results, n_cfg);
		$display("included degenerate clouds, a long output stall and one cloud past capacity");
		if (n_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end
endmodule
